// File: sv/thermal_frame_pec_checker_defines.svh
// Assertion macros used by the checker file.
`ifndef THERMAL_FRAME_PEC_CHECKER_DEFINES_SVH
`define THERMAL_FRAME_PEC_CHECKER_DEFINES_SVH

// Same-cycle implication.
`define TFPC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tfpc assertion failed");

// Next-cycle implication.
`define TFPC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tfpc assertion failed");

`endif

// File: sv/tfpc_pkg.sv
`default_nettype none

package tfpc_pkg;

   localparam int unsigned DEF_MAX_FRAME_BYTES = 64;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned WORD_W     = 16;
   localparam int unsigned POS_W      = 7;
   localparam int unsigned TW_W       = 5;
   localparam int unsigned KIND_W     = 2;
   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 8;

   localparam logic [POS_W-1:0]  MIN_FRAME_BYTES = 7'd3;
   localparam logic [TW_W-1:0]   MAX_TEMP_WORDS  = 5'd30;
   localparam logic [BYTE_W-1:0] CRC_POLY        = 8'h07;
   localparam logic [BYTE_W-1:0] CRC_TOP         = 8'h80;

   localparam logic [POS_W-1:0]  RST_FRAME_BYTES = 7'd35;
   localparam logic [TW_W-1:0]   RST_TEMP_WORDS  = 5'd16;
   localparam logic [BYTE_W-1:0] RST_SEED_BYTE   = 8'h15;

   typedef enum logic [KIND_W-1:0] {
      KIND_REF  = 2'd0,
      KIND_TEMP = 2'd1,
      KIND_PEC  = 2'd2
   } kind_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_FRAME_BYTES = 2'd0,
      REG_TEMP_WORDS  = 2'd1,
      REG_SEED_BYTE   = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [POS_W-1:0]  frame_bytes;
      logic [TW_W-1:0]   temp_words;
      logic [BYTE_W-1:0] seed_crc;
   } cfg_type;

   // CRC-8, MSB first, no final xor, zero initial value over one byte.
   function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] v);
      logic [BYTE_W-1:0] x;
      x = v;
      for (int k = 0; k < BYTE_W; k++) begin
         if ((x & CRC_TOP) != '0) begin
            x = (x << 1) ^ CRC_POLY;
         end else begin
            x = x << 1;
         end
      end
      return x;
   endfunction

endpackage

`default_nettype wire

// File: sv/tfpc_if.sv
`default_nettype none

interface tfpc_req_if import tfpc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;
   logic              frame_start;

   modport source (output valid, output rx_byte, output frame_start, input ready);
   modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface tfpc_rsp_if import tfpc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [WORD_W-1:0] word_value;
   logic [TW_W-1:0]   word_index;
   logic              pec_ok;
   logic              frame_end;

   modport source (output valid, output kind, output word_value, output word_index,
                   output pec_ok, output frame_end, input ready);
   modport sink   (input valid, input kind, input word_value, input word_index,
                   input pec_ok, input frame_end, output ready);
endinterface

interface tfpc_csr_if import tfpc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, output addr, output wdata, input ready);
   modport sink   (input valid, input addr, input wdata, output ready);
endinterface

`default_nettype wire

// File: sv/tfpc_csr.sv
`default_nettype none

module tfpc_csr import tfpc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   tfpc_csr_if.sink csr_chan,
   output cfg_type cfg
);

   logic [POS_W-1:0]  frame_bytes_ff, frame_bytes_in;
   logic [TW_W-1:0]   temp_words_ff, temp_words_in;
   logic [BYTE_W-1:0] seed_crc_ff, seed_crc_in;

   assign csr_chan.ready = 1'b1;

   // Keep the seed already run through the CRC, so a frame start loads it directly.
   always_comb begin
      frame_bytes_in = frame_bytes_ff;
      temp_words_in  = temp_words_ff;
      seed_crc_in    = seed_crc_ff;
      if (csr_chan.valid) begin
         case (reg_index_type'(csr_chan.addr))
            REG_FRAME_BYTES: frame_bytes_in = csr_chan.wdata[POS_W-1:0];
            REG_TEMP_WORDS:  temp_words_in  = csr_chan.wdata[TW_W-1:0];
            REG_SEED_BYTE:   seed_crc_in    = crc8_byte(csr_chan.wdata[BYTE_W-1:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_bytes_ff <= RST_FRAME_BYTES;
         temp_words_ff  <= RST_TEMP_WORDS;
         seed_crc_ff    <= crc8_byte(RST_SEED_BYTE);
      end else begin
         frame_bytes_ff <= frame_bytes_in;
         temp_words_ff  <= temp_words_in;
         seed_crc_ff    <= seed_crc_in;
      end
   end

   assign cfg.frame_bytes = frame_bytes_ff;
   assign cfg.temp_words  = temp_words_ff;
   assign cfg.seed_crc    = seed_crc_ff;

endmodule

`default_nettype wire

// File: sv/thermal_frame_pec_checker.sv
// Thermal sensor frame checker with CRC-8 packet error code.
// req_chan carries one received byte per transfer, frame_start marking the
// first byte of a frame; bytes outside a frame are dropped silently.
// rsp_chan carries zero or one result per byte: the reference word, the
// temperature words with their index, and the PEC check that ends the frame.
// csr_chan writes frame_bytes, temp_words and seed_byte; it is always ready
// and takes effect on the next byte. Write it only while no frame is in flight.
// Throughput: one byte per cycle while the receiver does not stall. Each
// byte passes an input register, then the CRC update and word assembly
// into the result register, which drives rsp_chan. The eight-step CRC
// update and the frame state close between those two registers.
// When the receiver stalls, the result register holds and the input register
// takes one more byte; req_chan.ready drops once both are full.
// Synchronous reset empties both registers, leaves the block idle until the
// next frame start and restores the register defaults.
`default_nettype none

module thermal_frame_pec_checker import tfpc_pkg::*; #(
   parameter int unsigned MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
) (
   input  logic       clock,
   input  logic       reset,
   tfpc_req_if.sink   req_chan,
   tfpc_rsp_if.source rsp_chan,
   tfpc_csr_if.sink   csr_chan
);

   localparam logic [POS_W:0] MaxFrame = (POS_W+1)'(MAX_FRAME_BYTES);
   localparam logic [POS_W:0] MinFrame = {1'b0, MIN_FRAME_BYTES};

   cfg_type cfg;

   tfpc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   // input register
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_start_ff;

   // frame state
   logic              active_ff, active_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [BYTE_W-1:0] crc_ff, crc_in;
   logic [BYTE_W-1:0] low_ff, low_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   kind_type          rsp_kind_ff, rsp_kind_in;
   logic [WORD_W-1:0] rsp_word_ff, rsp_word_in;
   logic [TW_W-1:0]   rsp_index_ff, rsp_index_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic              rsp_end_ff, rsp_end_in;

   logic              advance;
   logic              req_xfer;
   logic              emit;
   logic              act_cur;
   logic [POS_W-1:0]  pos_cur;
   logic [BYTE_W-1:0] crc_cur;
   logic [BYTE_W-1:0] low_cur;
   logic [POS_W:0]    frame_len;
   logic [POS_W:0]    last_pos;
   logic [TW_W-1:0]   tw_eff;
   logic [POS_W-2:0]  word_num;
   logic [POS_W-2:0]  temp_num;

   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_xfer       = req_chan.valid && req_chan.ready;

   always_comb begin
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // clamp the configured lengths
   always_comb begin
      frame_len = {1'b0, cfg.frame_bytes};
      if (frame_len < MinFrame) begin
         frame_len = MinFrame;
      end
      if (frame_len > MaxFrame) begin
         frame_len = MaxFrame;
      end
      last_pos = frame_len - 1'b1;
      tw_eff   = (cfg.temp_words > MAX_TEMP_WORDS) ? MAX_TEMP_WORDS : cfg.temp_words;
   end

   // frame start restarts the state before the byte is processed
   assign act_cur  = in_start_ff || active_ff;
   assign pos_cur  = in_start_ff ? '0 : pos_ff;
   assign crc_cur  = in_start_ff ? cfg.seed_crc : crc_ff;
   assign low_cur  = in_start_ff ? '0 : low_ff;
   assign word_num = pos_cur[POS_W-1:1];
   assign temp_num = word_num - 1'b1;

   always_comb begin
      active_in   = active_ff;
      pos_in      = pos_ff;
      crc_in      = crc_ff;
      low_in      = low_ff;
      emit        = 1'b0;
      rsp_kind_in = KIND_REF;
      rsp_word_in = '0;
      rsp_index_in = '0;
      rsp_ok_in   = 1'b0;
      rsp_end_in  = 1'b0;
      if (advance && act_cur) begin
         active_in = 1'b1;
         pos_in    = pos_cur;
         crc_in    = crc_cur;
         low_in    = low_cur;
         if ({1'b0, pos_cur} >= last_pos) begin
            // PEC byte: compare and close the frame
            emit        = 1'b1;
            rsp_kind_in = KIND_PEC;
            rsp_ok_in   = (crc_cur == in_byte_ff);
            rsp_end_in  = 1'b1;
            active_in   = 1'b0;
         end else begin
            crc_in = crc8_byte(in_byte_ff ^ crc_cur);
            pos_in = pos_cur + 1'b1;
            if (!pos_cur[0]) begin
               low_in = in_byte_ff;
            end else begin
               rsp_word_in = {in_byte_ff, low_cur};
               if (word_num == '0) begin
                  emit        = 1'b1;
                  rsp_kind_in = KIND_REF;
               end else if (temp_num < {1'b0, tw_eff}) begin
                  emit         = 1'b1;
                  rsp_kind_in  = KIND_TEMP;
                  rsp_index_in = temp_num[TW_W-1:0];
               end
            end
         end
      end
   end

   always_comb begin
      if (advance) begin
         rsp_valid_in = emit;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         active_ff    <= 1'b0;
         pos_ff       <= '0;
         crc_ff       <= '0;
         low_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         active_ff    <= active_in;
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         low_ff       <= low_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff  <= req_chan.rx_byte;
         in_start_ff <= req_chan.frame_start;
      end
      if (advance && emit) begin
         rsp_kind_ff  <= rsp_kind_in;
         rsp_word_ff  <= rsp_word_in;
         rsp_index_ff <= rsp_index_in;
         rsp_ok_ff    <= rsp_ok_in;
         rsp_end_ff   <= rsp_end_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.kind       = rsp_kind_ff;
   assign rsp_chan.word_value = rsp_word_ff;
   assign rsp_chan.word_index = rsp_index_ff;
   assign rsp_chan.pec_ok     = rsp_ok_ff;
   assign rsp_chan.frame_end  = rsp_end_ff;

endmodule

`default_nettype wire

// File: sv/tfpc_checker.sv
`default_nettype none
`include "thermal_frame_pec_checker_defines.svh"

module tfpc_checker import tfpc_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [KIND_W-1:0] rsp_kind,
   input logic [WORD_W-1:0] rsp_word_value,
   input logic [TW_W-1:0]   rsp_word_index,
   input logic              rsp_pec_ok,
   input logic              rsp_frame_end
);

   // a stalled result holds
   `TFPC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_word_value) && $stable(rsp_word_index) && $stable(rsp_pec_ok) && $stable(rsp_frame_end))

   // a result out of an empty output needs an earlier byte transfer
   `TFPC_ASSERT_IMPL(a_rsp_after_req, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready, 2))

   `TFPC_ASSERT_IMPL(a_end_on_check, clock, reset, rsp_valid, rsp_frame_end == (rsp_kind == KIND_PEC))

   `TFPC_ASSERT_IMPL(a_check_fields, clock, reset, rsp_valid && rsp_kind == KIND_PEC, rsp_word_value == '0 && rsp_word_index == '0)

   `TFPC_ASSERT_IMPL(a_word_fields, clock, reset, rsp_valid && rsp_kind != KIND_PEC, !rsp_pec_ok && (rsp_kind == KIND_TEMP || rsp_word_index == '0))

endmodule

bind thermal_frame_pec_checker tfpc_checker u_tfpc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_kind       (rsp_chan.kind),
   .rsp_word_value (rsp_chan.word_value),
   .rsp_word_index (rsp_chan.word_index),
   .rsp_pec_ok     (rsp_chan.pec_ok),
   .rsp_frame_end  (rsp_chan.frame_end)
);

`default_nettype wire
